[rtl/gtc_pkg.sv]
// ----------------------------------------------------------------------------
// gtc_pkg: shared types and codes for the glyph tile cache
// Entry and probe layouts, command, status and register index codes.
// ----------------------------------------------------------------------------
package gtc_pkg;

   localparam int unsigned KEY_W  = 14;
   localparam int unsigned SLOT_W = 10;

   localparam logic [SLOT_W-1:0] SLOT_MAX = 10'd1023;

   // request commands
   localparam logic [1:0] CMD_PLACE   = 2'd0;
   localparam logic [1:0] CMD_CLEAR   = 2'd1;
   localparam logic [1:0] CMD_RESERVE = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;

   // register indexes
   localparam logic CSR_TILE_BASE = 1'b0;
   localparam logic CSR_BLANK_ID  = 1'b1;

   // one cached pair: key is {color, glyph id}
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] slot;
   } entry_type;

   // lookup token that walks the row of cells
   typedef struct packed {
      logic              active;
      logic              match;
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] slot;
   } probe_type;

endpackage

[rtl/gtc_cell.sv]
// ----------------------------------------------------------------------------
// gtc_cell: one entry of the glyph tile cache
// Holds a single cached pair and passes the lookup token to its neighbor,
// marking it on a key match.
// ----------------------------------------------------------------------------
module gtc_cell
   import gtc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      live,
   input  logic      wr_en,
   input  entry_type wr_entry,
   input  probe_type prev_probe,
   output probe_type next_probe
);

   entry_type entry_ff;
   entry_type entry_in;
   probe_type probe_ff;
   probe_type probe_in;
   logic      match_now;

   assign match_now = prev_probe.active && !prev_probe.match && live &&
                      (entry_ff.key == prev_probe.key);

   always_comb begin
      entry_in = wr_en ? wr_entry : entry_ff;
      probe_in = prev_probe;
      if (match_now) begin
         probe_in.match = 1'b1;
         probe_in.slot  = entry_ff.slot;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign next_probe = probe_ff;

endmodule

[rtl/glyph_tile_cache.sv]
// ----------------------------------------------------------------------------
// glyph_tile_cache: character slot cache for (color, glyph id) pairs
// Looks up pairs in a row of entry cells, appends misses and hands out
// tilemap words; also clears the cache and reserves slots on request.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per valid/ready handshake; req_cmd selects place,
//            clear or reserve. Only one request is in flight at a time.
//   rsp_*  : exactly one response per request, in order, through an output
//            register; the next request is taken while a response waits.
//   csr_*  : write tile_base / blank_id while no request is in flight.
// Flow: a place request of a non-blank glyph walks a token through all
//   TABLE_DEPTH cells, one cell per cycle, then passes the finish step
//   into the output register. Blank, clear, reserve and unused commands
//   go straight from accept to the finish step.
// Pacing: a new request is taken only once the previous one has left the
//   finish step, so lookups are paced by the length of the cell row plus
//   the finish step and the other commands by the finish step alone.
// Reset: empties the cache, zeroes the slot counter, tile_base = 128 and
//   blank_id = 0. Cell contents are left as they are and are masked by
//   the fill count.
// Stall: while rsp_ready is low the response holds; a finished lookup
//   waits in the finish state until the output register frees.
// ----------------------------------------------------------------------------
module glyph_tile_cache
   import gtc_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [6:0]  req_color,
   input  logic [6:0]  req_glyph_id,
   input  logic [9:0]  req_reserve_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_tile_top,
   output logic [15:0] rsp_tile_bottom,
   output logic [9:0]  rsp_slot,
   output logic        rsp_hit,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // control and request registers
   logic [1:0]        state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [9:0]        rcount_ff, rcount_in;
   logic              blank_ff, blank_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_slot_ff, hit_slot_in;

   // cache state and registers
   logic [CNT_W-1:0]  entry_count_ff, entry_count_in;
   logic [SLOT_W-1:0] slot_counter_ff, slot_counter_in;
   logic [15:0]       tile_base_ff, tile_base_in;
   logic [6:0]        blank_id_ff, blank_id_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_tile_top_ff, rsp_tile_top_in;
   logic [15:0]       rsp_tile_bottom_ff, rsp_tile_bottom_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // cell row
   probe_type              probe_chain [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] cell_live;
   logic [TABLE_DEPTH-1:0] cell_wr;
   logic [TABLE_DEPTH-1:0] probe_busy;
   entry_type              new_entry;

   logic              accept;
   logic              start_scan;
   logic              finish_go;
   logic              append_go;
   logic              table_full;
   logic [SLOT_W-1:0] tile_slot;
   logic [15:0]       tile_top;
   logic [10:0]       rsv_sum;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign start_scan = accept && (req_cmd == CMD_PLACE) && (req_glyph_id != blank_id_ff);
   assign finish_go  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign table_full = (entry_count_ff == CNT_W'(TABLE_DEPTH));

   // append only on a real miss with room in the table and the counter
   assign append_go = finish_go && (cmd_ff == CMD_PLACE) && !blank_ff && !hit_ff &&
                      !table_full && (slot_counter_ff != SLOT_MAX);

   // tilemap words wrap modulo 2^16
   assign tile_slot = hit_ff ? hit_slot_ff : slot_counter_ff;
   assign tile_top  = tile_base_ff + {5'd0, tile_slot, 1'b0};
   assign rsv_sum   = {1'b0, slot_counter_ff} + {1'b0, rcount_ff};

   assign new_entry.key  = key_ff;
   assign new_entry.slot = slot_counter_ff;

   // inject the lookup token at the head of the row: active, match, key, slot
   assign probe_chain[0] = {start_scan, 1'b0, req_color, req_glyph_id, SLOT_W'(0)};

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign cell_live[i]  = (CNT_W'(i) < entry_count_ff);
      assign cell_wr[i]    = append_go && (entry_count_ff[IDX_W-1:0] == IDX_W'(i));
      assign probe_busy[i] = probe_chain[i+1].active;

      gtc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .live       (cell_live[i]),
         .wr_en      (cell_wr[i]),
         .wr_entry   (new_entry),
         .prev_probe (probe_chain[i]),
         .next_probe (probe_chain[i+1])
      );
   end

   always_comb begin
      state_in           = state_ff;
      cmd_in             = cmd_ff;
      key_in             = key_ff;
      rcount_in          = rcount_ff;
      blank_in           = blank_ff;
      hit_in             = hit_ff;
      hit_slot_in        = hit_slot_ff;
      entry_count_in     = entry_count_ff;
      slot_counter_in    = slot_counter_ff;
      tile_base_in       = tile_base_ff;
      blank_id_in        = blank_id_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_tile_top_in    = rsp_tile_top_ff;
      rsp_tile_bottom_in = rsp_tile_bottom_ff;
      rsp_slot_in        = rsp_slot_ff;
      rsp_hit_in         = rsp_hit_ff;
      rsp_status_in      = rsp_status_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_TILE_BASE: tile_base_in = csr_wdata;
            CSR_BLANK_ID:  blank_id_in  = csr_wdata[6:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_cmd;
               key_in    = {req_color, req_glyph_id};
               rcount_in = req_reserve_count;
               blank_in  = (req_glyph_id == blank_id_ff);
               hit_in    = 1'b0;
               state_in  = start_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            // token leaves the last cell: capture the lookup outcome
            if (probe_chain[TABLE_DEPTH].active) begin
               hit_in      = probe_chain[TABLE_DEPTH].match;
               hit_slot_in = probe_chain[TABLE_DEPTH].slot;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               rsp_valid_in       = 1'b1;
               rsp_tile_top_in    = '0;
               rsp_tile_bottom_in = '0;
               rsp_slot_in        = '0;
               rsp_hit_in         = 1'b0;
               rsp_status_in      = STAT_OK;
               state_in           = ST_IDLE;
               case (cmd_ff)
                  CMD_PLACE: begin
                     if (blank_ff) begin
                        // blank glyph: all zero, state kept
                     end else if (hit_ff || append_go) begin
                        rsp_tile_top_in    = tile_top;
                        rsp_tile_bottom_in = tile_top + 16'd1;
                        rsp_slot_in        = tile_slot;
                        rsp_hit_in         = hit_ff;
                        if (append_go) begin
                           entry_count_in  = entry_count_ff + CNT_W'(1);
                           slot_counter_in = slot_counter_ff + SLOT_W'(1);
                        end
                     end else if (table_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_status_in = STAT_OVERFLOW;
                     end
                  end
                  CMD_CLEAR: begin
                     entry_count_in  = '0;
                     slot_counter_in = '0;
                  end
                  CMD_RESERVE: begin
                     if (rsv_sum > {1'b0, SLOT_MAX}) begin
                        rsp_status_in = STAT_OVERFLOW;
                     end else begin
                        rsp_slot_in     = slot_counter_ff;
                        slot_counter_in = rsv_sum[SLOT_W-1:0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         entry_count_ff  <= '0;
         slot_counter_ff <= '0;
         tile_base_ff    <= 16'd128;
         blank_id_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         entry_count_ff  <= entry_count_in;
         slot_counter_ff <= slot_counter_in;
         tile_base_ff    <= tile_base_in;
         blank_id_ff     <= blank_id_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff             <= cmd_in;
      key_ff             <= key_in;
      rcount_ff          <= rcount_in;
      blank_ff           <= blank_in;
      hit_ff             <= hit_in;
      hit_slot_ff        <= hit_slot_in;
      rsp_tile_top_ff    <= rsp_tile_top_in;
      rsp_tile_bottom_ff <= rsp_tile_bottom_in;
      rsp_slot_ff        <= rsp_slot_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_status_ff      <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tile_top    = rsp_tile_top_ff;
   assign rsp_tile_bottom = rsp_tile_bottom_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(probe_busy))
      else $error("more than one lookup token in the cell row");

   a_idle_row_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (probe_busy == '0))
      else $error("lookup token in flight while taking requests");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_status == STAT_OK))
      else $error("hit reported with error status");
`endif

endmodule
